### hdl/sasmd_pkg.sv
`timescale 1ns / 1ps
package sasmd_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'b00,
    ST_OVF = 2'b01,
    ST_DZ  = 2'b10
  } status_t;

endpackage

### hdl/sasmd_queue.sv
`timescale 1ns / 1ps
module sasmd_queue #(
  parameter int DW    = 28,
  parameter int DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr,
  input  logic [DW-1:0]               wr_data,
  output logic                        full,
  input  logic                        rd,
  output logic                        rd_valid,
  output logic [DW-1:0]               rd_data,
  output logic [$clog2(DEPTH+1)-1:0]  level
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [DW-1:0] mem_r [0:DEPTH-1];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign level    = cnt_r;
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end
endmodule

### hdl/sasmd_front.sv
`timescale 1ns / 1ps
module sasmd_front import sasmd_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_cmd,
  input  logic signed [WIDTH-1:0] in_operand_a,
  input  logic signed [WIDTH-1:0] in_operand_b,
  output logic                   q_wr,
  output logic [3*WIDTH+3:0]     q_data,
  input  logic                   q_full
);
  logic [WIDTH-1:0] ua, ub, sum, dif, fast_lo;
  status_t          fast_st;
  cmd_t             cmd;

  assign ua  = in_operand_a;
  assign ub  = in_operand_b;
  assign cmd = cmd_t'(in_cmd);
  assign sum = ua + ub;
  assign dif = ua - ub;

  // resolve add and subtract here; multiply and divide go to the back end
  always_comb begin
    fast_lo = '0;
    fast_st = ST_OK;
    case (cmd)
      CMD_ADD: begin
        fast_lo = sum;
        if ((ua[WIDTH-1] == ub[WIDTH-1]) && (ua[WIDTH-1] != sum[WIDTH-1])) fast_st = ST_OVF;
      end
      CMD_SUB: begin
        fast_lo = dif;
        if ((ua[WIDTH-1] != ub[WIDTH-1]) && (ua[WIDTH-1] != dif[WIDTH-1])) fast_st = ST_OVF;
      end
      default: begin
        fast_lo = '0;
        fast_st = ST_OK;
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_wr     = in_valid && !q_full;
  assign q_data   = {in_cmd, ua, ub, fast_lo, fast_st};
endmodule

### hdl/sasmd_back.sv
`timescale 1ns / 1ps
module sasmd_back import sasmd_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  logic [3*WIDTH+3:0]   q_data,
  output logic                 q_rd,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WIDTH-1:0]     out_result_low,
  output logic [WIDTH-1:0]     out_result_high,
  output logic [1:0]           out_status
);
  localparam int W = WIDTH;

  cmd_t             h_cmd;
  logic [W-1:0]     h_a, h_b, h_lo, a_mag, b_mag;
  status_t          h_st, ld_st;
  logic [2*W-1:0]   prod;
  logic [W-1:0]     ld_lo, ld_hi;
  logic             adv;

  logic             v_r    [0:W];
  cmd_t             cmd_r  [0:W];
  logic [W-1:0]     lo_r   [0:W];
  logic [W-1:0]     hi_r   [0:W];
  status_t          st_r   [0:W];
  logic             qneg_r [0:W];
  logic             rneg_r [0:W];
  logic [W-1:0]     rem_r  [0:W];
  logic [W-1:0]     qd_r   [0:W];
  logic [W-1:0]     d_r    [0:W];

  logic             out_valid_r;
  logic [W-1:0]     out_lo_r, out_lo_nxt, out_hi_r, out_hi_nxt;
  status_t          out_st_r;
  logic [W-1:0]     qf, rf;

  assign h_cmd = cmd_t'(q_data[3*W+3 -: 2]);
  assign h_a   = q_data[3*W+1 -: W];
  assign h_b   = q_data[2*W+1 -: W];
  assign h_lo  = q_data[W+1 -: W];
  assign h_st  = status_t'(q_data[1:0]);

  // advance everything unless the output beat is held
  assign adv  = !(out_valid_r && out_stall);
  assign q_rd = adv;

  assign a_mag = h_a[W-1] ? (~h_a + 1'b1) : h_a;
  assign b_mag = h_b[W-1] ? (~h_b + 1'b1) : h_b;
  assign prod  = $signed(h_a) * $signed(h_b);

  always_comb begin
    ld_lo = h_lo;
    ld_hi = '0;
    ld_st = h_st;
    case (h_cmd)
      CMD_MUL: begin
        ld_lo = prod[W-1:0];
        ld_hi = prod[2*W-1:W];
        ld_st = ST_OK;
      end
      CMD_DIV: begin
        ld_lo = '0;
        ld_hi = h_a;
        if (h_b == '0) ld_st = ST_DZ;
        else if (h_a == {1'b1, {(W-1){1'b0}}} && h_b == '1) ld_st = ST_OVF;
        else ld_st = ST_OK;
      end
      default: begin
        ld_lo = h_lo;
        ld_hi = '0;
        ld_st = h_st;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_r[0]  <= h_cmd;
      lo_r[0]   <= ld_lo;
      hi_r[0]   <= ld_hi;
      st_r[0]   <= ld_st;
      qneg_r[0] <= h_a[W-1] ^ h_b[W-1];
      rneg_r[0] <= h_a[W-1];
      rem_r[0]  <= '0;
      qd_r[0]   <= a_mag;
      d_r[0]    <= b_mag;
    end
  end

  // one restoring divide step per stage
  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W:0]   t;
    logic         ge;
    logic [W:0]   diff;

    assign t    = {rem_r[k], qd_r[k][W-1]};
    assign diff = t - {1'b0, d_r[k]};
    assign ge   = (t >= {1'b0, d_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cmd_r[k+1]  <= cmd_r[k];
        lo_r[k+1]   <= lo_r[k];
        hi_r[k+1]   <= hi_r[k];
        st_r[k+1]   <= st_r[k];
        qneg_r[k+1] <= qneg_r[k];
        rneg_r[k+1] <= rneg_r[k];
        d_r[k+1]    <= d_r[k];
        rem_r[k+1]  <= ge ? diff[W-1:0] : t[W-1:0];
        qd_r[k+1]   <= {qd_r[k][W-2:0], ge};
      end
    end
  end

  assign qf = qneg_r[W] ? (~qd_r[W] + 1'b1) : qd_r[W];
  assign rf = rneg_r[W] ? (~rem_r[W] + 1'b1) : rem_r[W];

  always_comb begin
    out_lo_nxt = lo_r[W];
    out_hi_nxt = hi_r[W];
    if (cmd_r[W] == CMD_DIV) begin
      if (st_r[W] == ST_DZ) begin
        out_lo_nxt = '1;
      end else begin
        out_lo_nxt = qf;
        out_hi_nxt = rf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_lo_r <= out_lo_nxt;
      out_hi_r <= out_hi_nxt;
      out_st_r <= st_r[W];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_low  = out_lo_r;
  assign out_result_high = out_hi_r;
  assign out_status      = out_st_r;
endmodule

### hdl/signed_add_sub_mul_div_alu.sv
`timescale 1ns / 1ps
// Signed add / subtract / multiply / divide unit. One beat in gives one beat
// out, in order, at one beat per cycle when nothing stalls. The front end
// takes each beat, works out add and subtract with their overflow flag, and
// drops it into a DEPTH entry queue; the back end pops one entry per cycle,
// unless the output is stalled, into a WIDTH+2 stage pipeline (a register
// after the multiplier, then one restoring divide step per stage, then the
// sign fix-up into the output register). The divide pipeline length sets the
// latency, plus any time spent in the queue. Multiply returns the full
// 2*WIDTH-bit product as high and low words. Divide truncates toward zero
// and the remainder takes the dividend's sign; divide by zero reports status
// 2 with all ones low and the dividend high, and the most negative value
// over minus one reports status 1 with the wrapped quotient.
module signed_add_sub_mul_div_alu import sasmd_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_cmd,
  input  logic signed [WIDTH-1:0] in_operand_a,
  input  logic signed [WIDTH-1:0] in_operand_b,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [WIDTH-1:0]        out_result_low,
  output logic [WIDTH-1:0]        out_result_high,
  output logic [1:0]              out_status
);
  localparam int QW = 3*WIDTH + 4;
  localparam int CW = $clog2(DEPTH+1);

  logic          q_wr, q_full, q_rd, q_valid;
  logic [QW-1:0] q_wdata, q_rdata;
  logic [CW-1:0] q_level;

  // classify and resolve the cheap ops
  sasmd_front #(.WIDTH(WIDTH)) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .q_wr         (q_wr),
    .q_data       (q_wdata),
    .q_full       (q_full)
  );

  // decouple front and back so each side can stall on its own
  sasmd_queue #(.DW(QW), .DEPTH(DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wr_data  (q_wdata),
    .full     (q_full),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_data  (q_rdata),
    .level    (q_level)
  );

  // multiply and divide pipeline, plus output register
  sasmd_back #(.WIDTH(WIDTH)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_rdata),
    .q_rd            (q_rd),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_low  (out_result_low),
    .out_result_high (out_result_high),
    .out_status      (out_status)
  );

  // queue never holds more than its depth
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= CW'(DEPTH))
    else $error("queue level beyond depth");

  // divide by zero always reports all ones in the low word
  a_dz_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_DZ) |-> (out_result_low == '1))
    else $error("divide by zero low word not all ones");

  // overflow only comes from add, subtract or divide, all with a zero high word
  a_ovf_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OVF) |-> (out_result_high == '0))
    else $error("overflow beat with nonzero high word");
endmodule

### dv/tb_signed_add_sub_mul_div_alu.sv
`timescale 1ns / 1ps
// Checks the signed add / subtract / multiply / divide unit.
// A short table of hand-picked beats runs first; where the answer is plain
// (reset values, extremes, divide by zero) it is typed into the row.
// Random beats follow, mostly spread over the edges of the operand range.
// Beats with no typed answer go through a local arithmetic predictor. Each
// result beat is compared with the oldest queued answer.
module tb_signed_add_sub_mul_div_alu;
  import sasmd_pkg::*;

  localparam int W = 8;
  localparam int LAT = W + 2 + 4 + 8;
  localparam int N_RANDOM = 630;

  typedef struct packed {
    logic [W-1:0] lo;
    logic [W-1:0] hi;
    logic [1:0]   st;
  } alu_result_t;

  typedef struct {
    cmd_t         cmd;
    logic [W-1:0] a;
    logic [W-1:0] b;
    bit           typed;   // row carries a hand-written answer
    alu_result_t  ans;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = '0;
  logic signed [W-1:0] in_operand_a = '0;
  logic signed [W-1:0] in_operand_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [W-1:0] out_result_low;
  logic [W-1:0] out_result_high;
  logic [1:0] out_status;

  alu_result_t pending_results[$];
  int errors = 0;
  bit sender_done = 1'b0;
  bit hold_receiver = 1'b0;  // long hold-off request from the sender side
  bit quiet = 1'b0;          // stretch with no idling on either side

  always #2 clk = ~clk;

  signed_add_sub_mul_div_alu #(.WIDTH(W)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_low(out_result_low), .out_result_high(out_result_high),
    .out_status(out_status)
  );

  // Compute what the unit must return for one command and operand pair.
  function automatic alu_result_t alu_predict(cmd_t c, logic [W-1:0] a, logic [W-1:0] b);
    alu_result_t r;
    longint sa, sb, p, q, m;
    r = '0;
    sa = $signed(a);
    sb = $signed(b);
    case (c)
      CMD_ADD: begin
        r.lo = a + b;
        if (a[W-1] == b[W-1] && r.lo[W-1] != a[W-1]) r.st = ST_OVF;
      end
      CMD_SUB: begin
        r.lo = a - b;
        if (a[W-1] != b[W-1] && r.lo[W-1] != a[W-1]) r.st = ST_OVF;
      end
      CMD_MUL: begin
        p = sa * sb;
        r.lo = p[W-1:0];
        r.hi = p[2*W-1:W];
      end
      default: begin
        if (sb == 0) begin
          r.lo = '1;
          r.hi = a;
          r.st = ST_DZ;
        end else begin
          q = sa / sb;
          m = sa % sb;
          r.lo = q[W-1:0];
          r.hi = m[W-1:0];
          if (sb == -1 && a == {1'b1, {(W-1){1'b0}}}) r.st = ST_OVF;
        end
      end
    endcase
    return r;
  endfunction

  // Bias operands toward the edges of the range.
  function automatic logic [W-1:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return 8'h80;
      1: return 8'h7f;
      2: return 8'hff;
      3: return 8'($urandom_range(0, 2));
      default: return 8'($urandom);
    endcase
  endfunction

  stim_row_t directed_rows[$];

  task automatic add_row(cmd_t c, logic [W-1:0] a, logic [W-1:0] b, bit t = 0,
                         logic [W-1:0] lo = 0, logic [W-1:0] hi = 0, logic [1:0] st = 0);
    stim_row_t row;
    row.cmd = c;
    row.a = a;
    row.b = b;
    row.typed = t;
    row.ans = '{lo, hi, st};
    directed_rows = {directed_rows, row};
  endtask

  // Offer one beat and hold it until taken; queue its answer on acceptance.
  task automatic send_beat(cmd_t c, logic [W-1:0] a, logic [W-1:0] b, alu_result_t ans);
    in_valid <= 1'b1;
    in_cmd <= c;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results = {pending_results, ans};
  endtask

  task automatic maybe_idle();
    if (!quiet && !hold_receiver && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Sender
  initial begin
    alu_result_t ans;
    cmd_t c;
    logic [W-1:0] a, b;
    add_row(CMD_ADD, 8'h00, 8'h00, 1, 8'h00, 8'h00, ST_OK);
    add_row(CMD_ADD, 8'h7f, 8'h01, 1, 8'h80, 8'h00, ST_OVF);
    add_row(CMD_ADD, 8'h80, 8'hff, 1, 8'h7f, 8'h00, ST_OVF);
    add_row(CMD_ADD, 8'h80, 8'h80, 1, 8'h00, 8'h00, ST_OVF);
    add_row(CMD_ADD, 8'h7f, 8'h80);
    add_row(CMD_SUB, 8'h00, 8'h80, 1, 8'h80, 8'h00, ST_OVF);
    add_row(CMD_SUB, 8'h80, 8'h01, 1, 8'h7f, 8'h00, ST_OVF);
    add_row(CMD_SUB, 8'h05, 8'hfd);
    add_row(CMD_SUB, 8'hff, 8'h80, 1, 8'h7f, 8'h00, ST_OK);
    add_row(CMD_MUL, 8'h80, 8'h80, 1, 8'h00, 8'h40, ST_OK);
    add_row(CMD_MUL, 8'h7f, 8'h7f);
    add_row(CMD_MUL, 8'h80, 8'h7f);
    add_row(CMD_MUL, 8'hff, 8'hff, 1, 8'h01, 8'h00, ST_OK);
    add_row(CMD_MUL, 8'h80, 8'h01, 1, 8'h80, 8'hff, ST_OK);
    add_row(CMD_MUL, 8'h00, 8'h80, 1, 8'h00, 8'h00, ST_OK);
    add_row(CMD_DIV, 8'h37, 8'h00, 1, 8'hff, 8'h37, ST_DZ);
    add_row(CMD_DIV, 8'h80, 8'h00, 1, 8'hff, 8'h80, ST_DZ);
    add_row(CMD_DIV, 8'h80, 8'hff, 1, 8'h80, 8'h00, ST_OVF);
    add_row(CMD_DIV, 8'hf9, 8'h02, 1, 8'hfd, 8'hff, ST_OK);
    add_row(CMD_DIV, 8'h07, 8'hfe, 1, 8'hfd, 8'h01, ST_OK);
    add_row(CMD_DIV, 8'h80, 8'h7f);
    add_row(CMD_DIV, 8'h7f, 8'h80, 1, 8'h00, 8'h7f, ST_OK);
    add_row(CMD_DIV, 8'h80, 8'h80, 1, 8'h01, 8'h00, ST_OK);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      ans = directed_rows[i].typed ? directed_rows[i].ans :
            alu_predict(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b);
      send_beat(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b, ans);
      maybe_idle();
    end
    // Pause the sender until the unit has emptied.
    drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      // Ask for a long receiver hold-off so the unit fills and stalls input.
      if (n == 100) hold_receiver = 1'b1;
      if (n == 300) quiet = 1'b1;
      if (n == 400) quiet = 1'b0;
      if (n == 500) drain();
      c = cmd_t'($urandom_range(0, 3));
      a = pick_operand();
      b = pick_operand();
      send_beat(c, a, b, alu_predict(c, a, b));
      maybe_idle();
    end
    in_valid <= 1'b0;
    sender_done = 1'b1;
  end

  // Receiver: stall at random, with one long counted hold-off.
  initial begin
    int hold_count;
    hold_count = 0;
    forever begin
      @(posedge clk);
      if (hold_receiver && hold_count < 60) begin
        hold_count++;
        out_stall <= 1'b1;
        if (hold_count == 60) hold_receiver = 1'b0;
      end else begin
        out_stall <= (!quiet && $urandom_range(0, 99) < 19);
      end
    end
  end

  // Compare each accepted result beat with the oldest answer.
  always @(posedge clk) begin
    alu_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result lo=%h hi=%h st=%0d", $time,
                 out_result_low, out_result_high, out_status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_low !== want.lo) begin
          $display("%0t: result_low expected %h actual %h", $time, want.lo, out_result_low);
          errors++;
        end
        if (out_result_high !== want.hi) begin
          $display("%0t: result_high expected %h actual %h", $time, want.hi,
                   out_result_high);
          errors++;
        end
        if (out_status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, out_status);
          errors++;
        end
      end
    end
  end

  // Wrap up once everything sent has come back.
  initial begin
    wait (sender_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
    if (errors == 0)
      $display("signed_add_sub_mul_div_alu: match");
    else
      $display("signed_add_sub_mul_div_alu: mismatch");
    $finish;
  end

  initial begin
    #400000;
    $display("signed_add_sub_mul_div_alu: mismatch");
    $finish;
  end

endmodule

### files.f
hdl/sasmd_pkg.sv
hdl/sasmd_queue.sv
hdl/sasmd_front.sv
hdl/sasmd_back.sv
hdl/signed_add_sub_mul_div_alu.sv
dv/tb_signed_add_sub_mul_div_alu.sv
